FILE: rtl/sfr_pkg.sv
// Shared constants, types and helpers for the stream find-and-replace block.
// No dependencies; used by the other RTL files of the block but sfr_checker, and by the testbench.
`default_nettype none

package sfr_pkg;

  localparam int unsigned PatternMax = 8;
  localparam int unsigned ReplaceMax = 8;
  localparam int unsigned LenW       = 4;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned WordW      = 64;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned AddrW      = 5;

  // register indexes, taken from paddr[4:3]
  localparam logic [1:0] RegPattern    = 2'd0;
  localparam logic [1:0] RegPatternLen = 2'd1;
  localparam logic [1:0] RegReplace    = 2'd2;
  localparam logic [1:0] RegReplaceLen = 2'd3;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic load;     // take the input beat into the held line
    logic evict;    // emit oldest held byte after a broken match
    logic flush;    // emit oldest held byte on the final beat
    logic replace;  // emit one replacement byte
  } cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic prefix;     // held bytes are a prefix of the pattern
    logic full;       // held count equals pattern length
    logic count_one;  // exactly one byte held
    logic rep_last;   // replacement index at its last byte
    logic fin;        // current item carried the final marker
    logic out_free;   // output register can take a byte this cycle
  } status_t;

  // length of zero acts as one, anything above max acts as max
  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] v,
                                                input logic [LenW-1:0] max);
    logic [LenW-1:0] r;
    r = v;
    if (v == '0) r = LenW'(1);
    else if (v > max) r = max;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sfr_regs.sv
// APB register file: pattern, pattern length, replacement, replacement length.
// Depends on sfr_pkg.
`default_nettype none

module sfr_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sfr_pkg::AddrW-1:0]     paddr,
  input  wire logic [sfr_pkg::WordW-1:0]     pwdata,
  output logic      [sfr_pkg::WordW-1:0]     prdata,
  output logic                               pready,
  output logic      [sfr_pkg::WordW-1:0]     pattern_o,
  output logic      [sfr_pkg::LenW-1:0]      plen_o,
  output logic      [sfr_pkg::WordW-1:0]     replace_o,
  output logic      [sfr_pkg::LenW-1:0]      rlen_o,
  output logic                               clear_o
);

  logic [sfr_pkg::WordW-1:0] pattern_q, replace_q;
  logic [sfr_pkg::LenW-1:0]  plen_q, rlen_q;
  logic                      wr_en;
  logic [1:0]                idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      plen_q    <= sfr_pkg::LenW'(1);
      replace_q <= '0;
      rlen_q    <= sfr_pkg::LenW'(1);
    end else if (wr_en) begin
      case (idx)
        sfr_pkg::RegPattern:    pattern_q <= pwdata;
        sfr_pkg::RegPatternLen: plen_q    <= pwdata[sfr_pkg::LenW-1:0];
        sfr_pkg::RegReplace:    replace_q <= pwdata;
        sfr_pkg::RegReplaceLen: rlen_q    <= pwdata[sfr_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // a pattern change drops any partial match
  assign clear_o = wr_en & ((idx == sfr_pkg::RegPattern) | (idx == sfr_pkg::RegPatternLen));

  always_comb begin
    case (idx)
      sfr_pkg::RegPattern:    prdata = pattern_q;
      sfr_pkg::RegPatternLen: prdata = sfr_pkg::WordW'(plen_q);
      sfr_pkg::RegReplace:    prdata = replace_q;
      sfr_pkg::RegReplaceLen: prdata = sfr_pkg::WordW'(rlen_q);
      default:                prdata = '0;
    endcase
  end

  assign pattern_o = pattern_q;
  assign replace_o = replace_q;
  assign plen_o    = sfr_pkg::clamp_len(plen_q, sfr_pkg::LenW'(sfr_pkg::PatternMax));
  assign rlen_o    = sfr_pkg::clamp_len(rlen_q, sfr_pkg::LenW'(sfr_pkg::ReplaceMax));

endmodule

`default_nettype wire

FILE: rtl/sfr_datapath.sv
// Datapath: held byte line, prefix compare, replacement index, output register.
// Depends on sfr_pkg; driven by sfr_ctrl commands.
`default_nettype none

module sfr_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [sfr_pkg::WordW-1:0]  pattern_i,
  input  wire logic [sfr_pkg::LenW-1:0]   plen_i,
  input  wire logic [sfr_pkg::WordW-1:0]  replace_i,
  input  wire logic [sfr_pkg::LenW-1:0]   rlen_i,
  input  wire logic                       clear_i,
  input  wire logic [sfr_pkg::ByteW-1:0]  in_byte_i,
  input  wire logic                       in_last_i,
  input  wire sfr_pkg::cmd_t              cmd_i,
  output sfr_pkg::status_t                status_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [sfr_pkg::ByteW-1:0]  out_byte_o,
  output logic                            out_run_o,
  output logic                            out_text_o
);

  localparam int unsigned N = sfr_pkg::PatternMax;

  logic [sfr_pkg::ByteW-1:0] held_q [N];
  logic [sfr_pkg::LenW-1:0]  count_q, count_d, base;
  logic [sfr_pkg::IdxW-1:0]  rep_idx_q, rep_idx_d;
  logic                      fin_q;
  logic                      out_valid_q;
  logic [sfr_pkg::ByteW-1:0] out_byte_q;
  logic                      out_run_q, out_text_q;

  logic                      prefix, prefix_next, full, count_one, rep_last, out_free;
  logic                      emit, emit_run;
  logic [sfr_pkg::ByteW-1:0] emit_byte, rep_byte;

  assign base = (count_q >= plen_i) ? '0 : count_q;

  // compare held line against the pattern, and the line minus its oldest byte
  always_comb begin
    prefix      = 1'b1;
    prefix_next = 1'b1;
    for (int i = 0; i < N; i++) begin
      if ((sfr_pkg::LenW'(i) < count_q) &&
          (held_q[i] != pattern_i[i*sfr_pkg::ByteW +: sfr_pkg::ByteW]))
        prefix = 1'b0;
    end
    for (int i = 0; i < N - 1; i++) begin
      if ((sfr_pkg::LenW'(i + 1) < count_q) &&
          (held_q[i+1] != pattern_i[i*sfr_pkg::ByteW +: sfr_pkg::ByteW]))
        prefix_next = 1'b0;
    end
  end

  assign full      = (count_q == plen_i);
  assign count_one = (count_q == sfr_pkg::LenW'(1));
  assign rep_last  = ((sfr_pkg::LenW'(rep_idx_q) + sfr_pkg::LenW'(1)) == rlen_i);
  assign out_free  = ~out_valid_q | out_ready_i;
  assign rep_byte  = replace_i[{rep_idx_q, 3'b000} +: sfr_pkg::ByteW];

  assign status_o = '{prefix:    prefix,
                      full:      full,
                      count_one: count_one,
                      rep_last:  rep_last,
                      fin:       fin_q,
                      out_free:  out_free};

  assign emit      = cmd_i.evict | cmd_i.flush | cmd_i.replace;
  assign emit_byte = cmd_i.replace ? rep_byte : held_q[0];

  always_comb begin
    emit_run = 1'b0;
    if (cmd_i.replace)    emit_run = rep_last;
    else if (cmd_i.flush) emit_run = count_one;
    else if (cmd_i.evict) emit_run = count_one | (~fin_q & prefix_next);
  end

  always_comb begin
    count_d = count_q;
    if (clear_i) count_d = '0;
    else if (cmd_i.load) count_d = base + sfr_pkg::LenW'(1);
    else if (cmd_i.evict | cmd_i.flush) count_d = count_q - sfr_pkg::LenW'(1);
    else if (cmd_i.replace & rep_last) count_d = '0;
  end

  always_comb begin
    rep_idx_d = rep_idx_q;
    if (cmd_i.load) rep_idx_d = '0;
    else if (cmd_i.replace) rep_idx_d = rep_last ? '0 : rep_idx_q + sfr_pkg::IdxW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rep_idx_q   <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      rep_idx_q <= rep_idx_d;
      if (cmd_i.load) fin_q <= in_last_i;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // held line: append at the fill point, advance toward entry 0 on release
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      held_q[base[sfr_pkg::IdxW-1:0]] <= in_byte_i;
    end else if (cmd_i.evict | cmd_i.flush) begin
      for (int i = 0; i < N - 1; i++) held_q[i] <= held_q[i+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_byte;
      out_run_q  <= emit_run;
      out_text_q <= emit_run & fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_run_o   = out_run_q;
  assign out_text_o  = out_text_q;

endmodule

`default_nettype wire

FILE: rtl/sfr_ctrl.sv
// Sequencer: accepts one beat, then checks, releases, replaces or flushes.
// Depends on sfr_pkg; drives sfr_datapath through cmd_t.
`default_nettype none

module sfr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sfr_pkg::status_t  status_i,
  output sfr_pkg::cmd_t          cmd_o
);

  typedef enum logic [4:0] {
    StIdle    = 5'b00001,
    StCheck   = 5'b00010,
    StRelease = 5'b00100,
    StReplace = 5'b01000,
    StFlush   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (status_i.prefix && status_i.full) state_d = StReplace;
        else if (status_i.prefix)             state_d = status_i.fin ? StFlush : StIdle;
        else                                  state_d = StRelease;
      end
      StRelease: begin
        if (status_i.out_free) begin
          cmd_o.evict = 1'b1;
          state_d     = status_i.count_one ? StIdle : StCheck;
        end
      end
      StReplace: begin
        if (status_i.out_free) begin
          cmd_o.replace = 1'b1;
          if (status_i.rep_last) state_d = StIdle;
        end
      end
      StFlush: begin
        if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          if (status_i.count_one) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

endmodule

`default_nettype wire

FILE: rtl/stream_find_and_replace.sv
// Stream find-and-replace, top level: APB registers, sequencer, datapath.
// Depends on sfr_pkg, sfr_regs, sfr_ctrl, sfr_datapath.
// Flow: one beat in flight; a new beat is taken only once the sequencer has checked the
//   held line and emitted every byte it releases, replaces or flushes, and output stalls
//   hold that up; each emitted byte leaves from a register in the cycle after it is emitted.
// Reset (rst_ni low, asynchronous): held line and output empty, registers 0, lengths 1.
`default_nettype none

module stream_find_and_replace (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input beats
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // final_byte
  // result beats
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tuser,   // [0] run_end
  output logic             m_axis_tlast,   // text_end
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

  logic [sfr_pkg::WordW-1:0] pattern, replace;
  logic [sfr_pkg::LenW-1:0]  plen, rlen;
  logic                      clear;
  sfr_pkg::cmd_t             cmd;
  sfr_pkg::status_t          status;

  // Registers; lengths come out already clamped to 1..max.
  sfr_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pattern_o (pattern),
    .plen_o    (plen),
    .replace_o (replace),
    .rlen_o    (rlen),
    .clear_o   (clear)
  );

  // Sequencer: take a beat, compare, then emit byte by byte while the
  // output register has room.
  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Held line, compare logic and output register.
  sfr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pattern_i   (pattern),
    .plen_i      (plen),
    .replace_i   (replace),
    .rlen_i      (rlen),
    .clear_i     (clear),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_run_o   (m_axis_tuser),
    .out_text_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/sfr_checker.sv
// Port-level checks for stream_find_and_replace, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module sfr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tuser,
  input wire logic       m_axis_tlast
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  // end of text is always the end of a run
  a_text_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("text end without run end");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while previous item in work");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: test/tb_stream_find_and_replace.sv
// Self-checking testbench for stream_find_and_replace: directed texts, then random texts
// under random pattern and replacement settings, checked beat by beat against a predictor.
// Depends on sfr_pkg and the stream_find_and_replace RTL only.
`timescale 1ns / 1ps

module tb_stream_find_and_replace;

  localparam int RandItems = 345;     // random input beats after the directed part, at least
  localparam int PhaseItems = 25;     // input beats per random configuration, at least
  localparam int SettleCycles = 40;   // covers a beat still in flight that yields nothing
  localparam int CycleLimit = 400000; // far above the slowest correct run

  // one result beat of the rewritten text
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       text_end;
  } text_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;  // final_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] out_byte
  logic        m_axis_tuser;         // [0] run_end
  logic        m_axis_tlast;         // text_end
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  stream_find_and_replace u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial forever #1 clk_i = ~clk_i;

  // Predictor state: register copies and the held line of pattern-prefix bytes.
  logic [63:0] pat_word = '0;
  logic [3:0]  pat_len = 4'd1;
  logic [63:0] rep_word = '0;
  logic [3:0]  rep_len = 4'd1;
  logic [7:0]  held_line [sfr_pkg::PatternMax];
  int          held_cnt = 0;

  text_beat_t  rewrite_q [$];  // rewritten bytes still owed by the block
  bit          idle_on = 1'b1; // random gaps on both sides when set
  int          err_cnt = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          match_cnt = 0;
  int          write_cnt = 0;
  int          rand_items = 0;
  int          cycle_cnt = 0;

  // Zero acts as one; anything above the maximum acts as the maximum.
  function automatic int eff_len(input logic [3:0] v, input int maxv);
    if (v == 4'd0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic bit held_matches(input int n);
    for (int i = 0; i < n; i++)
      if (held_line[i] != pat_word[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // Mirror a register write; a pattern change drops whatever is held.
  function automatic void settings_write(input logic [1:0] idx, input logic [63:0] value);
    case (idx)
      sfr_pkg::RegPattern: begin
        pat_word = value;
        held_cnt = 0;
      end
      sfr_pkg::RegPatternLen: begin
        pat_len = value[3:0];
        held_cnt = 0;
      end
      sfr_pkg::RegReplace:    rep_word = value;
      sfr_pkg::RegReplaceLen: rep_len = value[3:0];
      default: ;
    endcase
  endfunction

  // Work out the bytes one input beat releases and queue them for the checker.
  function automatic void rewrite_step(input logic [7:0] din, input logic fin);
    text_beat_t step_q [$];
    text_beat_t b;
    int plen;
    int rlen;
    plen = eff_len(pat_len, sfr_pkg::PatternMax);
    rlen = eff_len(rep_len, sfr_pkg::ReplaceMax);
    if (held_cnt >= plen) held_cnt = 0;
    held_line[held_cnt] = din;
    held_cnt++;
    // naive search: release the oldest held byte until the rest is a prefix again
    while (held_cnt > 0) begin
      if (held_matches(held_cnt)) begin
        if (held_cnt == plen) begin
          for (int i = 0; i < rlen; i++) step_q.push_back({rep_word[8*i +: 8], 2'b00});
          held_cnt = 0;
          match_cnt++;
        end
        break;
      end
      step_q.push_back({held_line[0], 2'b00});
      for (int i = 0; i + 1 < held_cnt; i++) held_line[i] = held_line[i+1];
      held_cnt--;
    end
    if (fin) begin
      for (int i = 0; i < held_cnt; i++) step_q.push_back({held_line[i], 2'b00});
      held_cnt = 0;
    end
    if (step_q.size() > 0) begin
      b = step_q.pop_back();
      b.run_end = 1'b1;
      b.text_end = fin;
      step_q.push_back(b);
    end
    foreach (step_q[k]) rewrite_q.push_back(step_q[k]);
  endfunction

  // APB write: setup, access, then idle with psel low. Call at a rising edge.
  task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // register takes the value at this edge
    settings_write(idx, value);
    write_cnt++;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_rewrite(input logic [63:0] pat, input logic [3:0] plen,
                             input logic [63:0] rep, input logic [3:0] rlen);
    reg_write(sfr_pkg::RegReplace, rep);
    reg_write(sfr_pkg::RegReplaceLen, {60'd0, rlen});
    reg_write(sfr_pkg::RegPattern, pat);
    reg_write(sfr_pkg::RegPatternLen, {60'd0, plen});
  endtask

  // Offer one beat, with a random gap first; valid stays high into the next beat
  // unless that beat opens with a gap.
  task automatic send_beat(input logic [7:0] d, input logic last);
    int gap;
    gap = 0;
    if (idle_on) while ($urandom_range(99) < 38) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rewrite_step(d, last);
    beats_in++;
  endtask

  // Drop valid, wait for every owed byte, then let a silent beat settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (rewrite_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Receiver stalls at random while idling is on.
  always @(posedge clk_i) begin
    m_axis_tready <= idle_on ? ($urandom_range(99) >= 38) : 1'b1;
  end

  // Compare each accepted result beat with the oldest owed byte.
  text_beat_t want;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_out++;
      if (rewrite_q.size() == 0) begin
        $error("result beat with nothing owed: out_byte %02h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = rewrite_q.pop_front();
        if (m_axis_tdata !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tuser !== want.run_end) begin
          $error("run_end: expected %0b, got %0b", want.run_end, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tlast !== want.text_end) begin
          $error("text_end: expected %0b, got %0b", want.text_end, m_axis_tlast);
          err_cnt++;
        end
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycle_cnt, rewrite_q.size());
      $display("stream_find_and_replace test failed");
      $finish;
    end
  end

  // Reset values: one-byte pattern 00 replaced by 00; byte extremes pass.
  task automatic test_reset_values();
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    drain();
  endtask

  // Pattern "aab": a broken prefix releases one byte and rescans the rest;
  // the final beat flushes a held prefix.
  task automatic test_partial_and_rescan();
    logic [7:0] txt [7];
    txt = '{8'h7A, 8'h61, 8'h61, 8'h61, 8'h62, 8'h61, 8'h61};
    set_rewrite(64'h626161, 4'd3, 64'h5958, 4'd2);
    foreach (txt[k]) send_beat(txt[k], k == 6);
    drain();
  endtask

  // Eight-byte pattern: a three-byte prefix broken by a 00 byte, then a full
  // match that lands on the final beat with an eight-byte replacement.
  task automatic test_widest_pattern();
    set_rewrite({8{8'hFF}}, 4'd8, 64'h0123456789ABCDEF, 4'd8);
    repeat (3) send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    for (int k = 0; k < 8; k++) send_beat(8'hFF, k == 7);
    drain();
  endtask

  // Lengths of zero act as one; lengths above eight act as eight.
  task automatic test_length_clamping();
    set_rewrite(64'h5A, 4'd0, 64'hC3, 4'd0);
    send_beat(8'h5A, 1'b1);
    drain();
    set_rewrite({8{8'hA5}}, 4'd15, 64'hFEDCBA9876543210, 4'd15);
    send_beat(8'hA5, 1'b1);
    drain();
  endtask

  // Bytes held mid-text are dropped when the pattern is rewritten.
  task automatic test_pattern_change_midtext();
    set_rewrite(64'h636261, 4'd3, 64'h2A, 4'd1);
    send_beat(8'h61, 1'b0);
    send_beat(8'h62, 1'b0);
    drain();
    reg_write(sfr_pkg::RegPattern, 64'h646362);
    send_beat(8'h63, 1'b1);
    drain();
  endtask

  // Random settings per phase; texts are mostly pattern copies, prefixes and
  // pattern bytes so matches and broken matches are frequent, plus noise bytes.
  task automatic test_random_texts();
    int phase;
    int phase_items;
    int plen;
    int tlen;
    int pick;
    int cut;
    bit open_end;
    logic [3:0] plen_v;
    logic [3:0] rlen_v;
    logic [63:0] pat;
    logic [7:0] alpha [3];
    logic [7:0] txt [$];
    phase = 0;
    while (rand_items < RandItems) begin
      // a run of phases with no gaps and no stalls
      idle_on = !(phase >= 4 && phase < 7);
      case ($urandom_range(5))
        0: plen_v = 4'd0;
        1: plen_v = 4'd15;
        2: plen_v = 4'd8;
        default: plen_v = 4'($urandom_range(1, 8));
      endcase
      if ($urandom_range(3) == 0) begin
        pat = {$urandom, $urandom};
      end else begin
        foreach (alpha[k]) alpha[k] = 8'($urandom);
        cut = $urandom_range(2);
        for (int i = 0; i < 8; i++) pat[8*i +: 8] = alpha[$urandom_range(cut)];
      end
      rlen_v = 4'($urandom_range(15));
      set_rewrite(pat, plen_v, {$urandom, $urandom}, rlen_v);
      plen = eff_len(plen_v, sfr_pkg::PatternMax);
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        tlen = $urandom_range(1, 20);
        txt.delete();
        while (txt.size() < tlen) begin
          pick = $urandom_range(9);
          if (pick < 3) begin
            for (int i = 0; i < plen; i++) txt.push_back(pat[8*i +: 8]);
          end else if (pick < 5 && plen > 1) begin
            cut = $urandom_range(1, plen - 1);
            for (int i = 0; i < cut; i++) txt.push_back(pat[8*i +: 8]);
          end else if (pick < 8) begin
            txt.push_back(pat[8*$urandom_range(plen - 1) +: 8]);
          end else begin
            txt.push_back(8'($urandom));
          end
        end
        // now and then leave a text open so it runs on, or is cut by the next settings
        open_end = ($urandom_range(99) < 12);
        foreach (txt[k]) send_beat(txt[k], (k == txt.size() - 1) && !open_end);
        phase_items += txt.size();
      end
      rand_items += phase_items;
      drain();
      phase++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_partial_and_rescan();
    test_widest_pattern();
    test_length_clamping();
    test_pattern_change_midtext();
    test_random_texts();

    drain();
    $display("sent %0d input beats, checked %0d rewritten bytes, %0d replacements",
             beats_in, beats_out, match_cnt);
    $display("%0d register writes, pattern and replacement lengths 0 through 15",
             write_cnt);
    if (err_cnt == 0 && rewrite_q.size() == 0) begin
      $display("stream_find_and_replace test passed");
    end else begin
      $display("%0d mismatches, %0d bytes never produced", err_cnt, rewrite_q.size());
      $display("stream_find_and_replace test failed");
    end
    $finish;
  end

endmodule
